@@ hw/rtl/websocket_frame_parser_top_defines.svh @@
// ----------------------------------------------------------------------------
// websocket frame parser assertion macros
// shared concurrent property forms, clocked on aclk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_PARSER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define WFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/wfp_pkg.sv @@
// ----------------------------------------------------------------------------
// wfp_pkg
// shared widths, result kinds and the result record of the frame parser
// ----------------------------------------------------------------------------
package wfp_pkg;

    localparam int LEN_BITS = 32;
    localparam int POS_W    = 32;
    localparam int OUT_LEN_W = 32;
    localparam int M_DATA_W = 48;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           payload;
        logic [3:0]           opcode;
        logic                 fin;
        logic                 masked;
        logic [LEN_BITS-1:0]  length;
        logic                 done;
    } wfp_result_t;

endpackage

@@ hw/rtl/wfp_parser.sv @@
// ----------------------------------------------------------------------------
// wfp_parser
// header state machine and payload unmasking, one byte per accepted request
// ----------------------------------------------------------------------------
module wfp_parser
    import wfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        res_valid,
    output wfp_result_t res
);

    localparam logic [2:0] PH_HDR0  = 3'd0;
    localparam logic [2:0] PH_HDR1  = 3'd1;
    localparam logic [2:0] PH_EXT16 = 3'd2;
    localparam logic [2:0] PH_EXT64 = 3'd3;
    localparam logic [2:0] PH_KEY   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;

    logic [2:0]          phase_reg, phase_next;
    logic [2:0]          count_reg, count_next;
    logic                fin_reg, fin_next;
    logic [3:0]          opcode_reg, opcode_next;
    logic                mask_reg, mask_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [31:0]         key_reg, key_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                discard_reg, discard_next;

    logic [LEN_BITS-1:0] len_shift;
    logic [POS_W-1:0]    pos_inc;
    logic [7:0]          key_byte;
    logic                length_done;
    logic                header_done;
    logic                hit;
    logic [1:0]          kind;
    logic [7:0]          data;
    logic                done;

    assign len_shift = {len_reg[LEN_BITS-9:0], in_byte};
    assign pos_inc   = pos_reg + POS_W'(1);

    always_comb begin
        case (pos_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        fin_next     = fin_reg;
        opcode_next  = opcode_reg;
        mask_next    = mask_reg;
        len_next     = len_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        discard_next = discard_reg;
        length_done  = 1'b0;
        header_done  = 1'b0;
        hit          = 1'b0;
        kind         = KIND_PAYLOAD;
        data         = 8'd0;
        done         = 1'b0;

        if (discard_reg) begin
            if (in_last) begin
                discard_next = 1'b0;
            end
        end else begin
            case (phase_reg)
                PH_HDR1: begin
                    mask_next  = in_byte[7];
                    count_next = 3'd0;
                    len_next   = '0;
                    if (in_byte[6:0] == 7'd126) begin
                        phase_next = PH_EXT16;
                    end else if (in_byte[6:0] == 7'd127) begin
                        phase_next = PH_EXT64;
                    end else begin
                        len_next    = LEN_BITS'(in_byte[6:0]);
                        length_done = 1'b1;
                    end
                end
                PH_EXT16: begin
                    len_next = len_shift;
                    if (count_reg >= 3'd1) begin
                        length_done = 1'b1;
                    end else begin
                        count_next = count_reg + 3'd1;
                    end
                end
                PH_EXT64: begin
                    if (count_reg >= 3'd4) begin
                        len_next = len_shift;
                    end
                    if (count_reg >= 3'd7) begin
                        length_done = 1'b1;
                    end else begin
                        count_next = count_reg + 3'd1;
                    end
                end
                PH_KEY: begin
                    key_next = {key_reg[23:0], in_byte};
                    if (count_reg >= 3'd3) begin
                        header_done = 1'b1;
                    end else begin
                        count_next = count_reg + 3'd1;
                    end
                end
                PH_DATA: begin
                    hit      = 1'b1;
                    kind     = KIND_PAYLOAD;
                    data     = mask_reg ? (in_byte ^ key_byte) : in_byte;
                    done     = (pos_inc >= POS_W'(len_reg));
                    pos_next = pos_inc;
                    if (done) begin
                        phase_next = PH_HDR0;
                        pos_next   = '0;
                    end
                end
                default: begin
                    fin_next    = in_byte[7];
                    opcode_next = in_byte[3:0];
                    mask_next   = 1'b0;
                    len_next    = '0;
                    count_next  = 3'd0;
                    pos_next    = '0;
                    if (in_byte[3:0] > 4'hA) begin
                        phase_next   = PH_HDR0;
                        discard_next = !in_last;
                        hit          = 1'b1;
                        kind         = KIND_REJECT;
                        done         = 1'b1;
                    end else begin
                        phase_next = PH_HDR1;
                    end
                end
            endcase

            if (length_done) begin
                count_next = 3'd0;
                if (mask_next) begin
                    key_next   = '0;
                    phase_next = PH_KEY;
                end else begin
                    header_done = 1'b1;
                end
            end

            if (header_done) begin
                pos_next   = '0;
                count_next = 3'd0;
                if (len_next == '0) begin
                    phase_next = PH_HDR0;
                    hit        = 1'b1;
                    kind       = KIND_EMPTY;
                    done       = 1'b1;
                end else begin
                    phase_next = PH_DATA;
                end
            end
        end
    end

    assign res_valid  = in_fire && hit;
    assign res.kind    = kind;
    assign res.payload = data;
    assign res.opcode  = opcode_next;
    assign res.fin     = fin_next;
    assign res.masked  = mask_next;
    assign res.length  = len_next;
    assign res.done    = done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR0;
            count_reg   <= 3'd0;
            fin_reg     <= 1'b0;
            opcode_reg  <= 4'd0;
            mask_reg    <= 1'b0;
            len_reg     <= '0;
            key_reg     <= '0;
            pos_reg     <= '0;
            discard_reg <= 1'b0;
        end else if (in_fire) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            fin_reg     <= fin_next;
            opcode_reg  <= opcode_next;
            mask_reg    <= mask_next;
            len_reg     <= len_next;
            key_reg     <= key_next;
            pos_reg     <= pos_next;
            discard_reg <= discard_next;
        end
    end

endmodule

@@ hw/rtl/wfp_out_skid.sv @@
// ----------------------------------------------------------------------------
// wfp_out_skid
// result register plus one skid slot; input ready is a register, not m_tready
// ----------------------------------------------------------------------------
module wfp_out_skid
    import wfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  wfp_result_t push_data,
    output logic        can_accept,
    output logic        out_valid,
    input  logic        out_ready,
    output wfp_result_t out_data
);

    logic        out_valid_reg;
    wfp_result_t out_reg;
    logic        skid_valid_reg;
    wfp_result_t skid_reg;
    logic        pop;

    assign pop        = out_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_reg <= push_data;
            end else begin
                out_reg <= push_data;
            end
        end
    end

endmodule

@@ hw/rtl/websocket_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_parser_top
// receive-side websocket deframer: header parse, length decode, unmasking
// ----------------------------------------------------------------------------
//  channel  dir  tdata                      tuser        tlast
//  s_       in   rx_byte[7:0]               -            chunk_end
//  m_       out  payload,opcode,fin,masked, result_kind  frame_done
//                length (see port comment)
//
//  one byte request per clock while s_tready is high, results are registered
//  header bytes give no result, payload bytes one each, empty frame or rejection one
//  reset clears the parser to the first-header-byte phase and drops results
//  s_tready falls only while both result register and skid slot are full
// ----------------------------------------------------------------------------
`include "websocket_frame_parser_top_defines.svh"

module websocket_frame_parser_top
    import wfp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // rx_byte
    input  logic                s_tlast,   // chunk_end
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // payload_byte, frame_opcode, frame_fin,
                                           // frame_was_masked, frame_length, zero pad
    output logic [1:0]          m_tuser,   // result_kind
    output logic                m_tlast    // frame_done
);

    logic        in_fire;
    logic        res_valid;
    wfp_result_t res;
    wfp_result_t out_res;

    assign in_fire = s_tvalid && s_tready;

    wfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    wfp_out_skid u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_data  (res),
        .can_accept (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    assign m_tdata = {2'b00, OUT_LEN_W'(out_res.length), out_res.masked, out_res.fin,
                      out_res.opcode, out_res.payload};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.done;

    `WFP_ASSERT_NOW(a_stall_has_result, !s_tready, m_tvalid, "input stalled with no result")
    `WFP_ASSERT_NOW(a_nonpayload_clean, m_tvalid && m_tuser != KIND_PAYLOAD,
                    m_tlast && m_tdata[7:0] == 8'd0, "non-payload result not clean")
    `WFP_ASSERT_NOW(a_reject_no_header, m_tvalid && m_tuser == KIND_REJECT,
                    m_tdata[45:13] == 33'd0, "rejection carries length or mask")
    `WFP_ASSERT_NEXT(a_full_holds, m_tvalid && !m_tready && !s_tready,
                     m_tvalid && !s_tready, "full buffer lost an entry")

endmodule
